// ----- rtl/rfu_pkg.sv -----
`timescale 1ns / 1ps
package rfu_pkg;

  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 17;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMESTAMP_STEP = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PAYLOAD    = 4'd1;

  localparam logic [16:0] TIMESTAMP_STEP_RESET = 17'd3600;
  localparam logic [10:0] MAX_PAYLOAD_RESET    = 11'd1400;
  localparam logic [10:0] PAYLOAD_MIN          = 11'd1024;
  localparam logic [10:0] PAYLOAD_MAX          = 11'd1400;

  localparam logic [4:0]  FU_A_TYPE            = 5'd28;
  localparam logic [10:0] SINGLE_OVERHEAD      = 11'd13;  // RTP header plus NAL header
  localparam logic [10:0] FU_OVERHEAD          = 11'd14;  // RTP header plus FU bytes

  localparam int FRAG_IDX_BITS = 6;  // up to 64 fragments per NAL unit

  // Per-NAL job handed from the front to the back.
  typedef struct packed {
    logic [7:0]  hdr;
    logic        single;
    logic [10:0] max_pay;
    logic [31:0] ts;
  } job_ctl_t;

  // One packet descriptor on the result side.
  typedef struct packed {
    logic [15:0] seq_number;
    logic [31:0] timestamp;
    logic        marker;
    logic        fragmented;
    logic [7:0]  lead_byte;
    logic [7:0]  fu_hdr;
    logic [15:0] payload_offset;
    logic [10:0] payload_length;
    logic [10:0] packet_bytes;
    logic        last;
  } pkt_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_FRAG
  } back_state_t;

endpackage

// ----- rtl/rtp_h264_fua_packetizer.sv -----
`timescale 1ns / 1ps
// RTP packetizer for H.264 NAL unit descriptors (single-NAL and FU-A packets).
// Input channel: the user presents a NAL header byte and a NAL length and
// raises in_push; the request is taken at a clock edge where in_full is low.
// Result channel: while out_empty is low the oldest packet descriptor sits
// on the out_ ports; raising out_pop takes it at the next edge.
// Configuration: cfg_valid with cfg_index 0 writes the timestamp step and
// index 1 writes the fragment payload size; cfg_ready is always high. Write
// registers only while no request is in flight.
// The front stage stamps each request with its timestamp and classifies it
// as single or fragmented, then places it in a two-entry job queue, so up to
// two requests may be taken while the back stage is busy.
// The back stage emits one descriptor per cycle from its output register
// while that register is free or being popped: a single packet is emitted
// directly; a fragmented NAL with n fragments (n up to 64) first loads its
// fragment registers, then emits one fragment per cycle. A packet reaches
// the out_ ports from the job queue through the output register.
// A stalled receiver holds the output register; the back stage waits and
// the queue fills, after which in_full rises. Reset clears the sequence
// number and timestamp to zero and restores both configuration registers.
module rtp_h264_fua_packetizer import rfu_pkg::*; #(
  parameter int NAL_LENGTH_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  // Request side
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [7:0]                 in_nal_header,
  input  logic [NAL_LENGTH_BITS-1:0] in_nal_length,
  // Result side
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [15:0]                out_seq_number,
  output logic [31:0]                out_timestamp,
  output logic                       out_marker,
  output logic                       out_fragmented,
  output logic [7:0]                 out_lead_byte,
  output logic [7:0]                 out_fu_hdr,
  output logic [15:0]                out_payload_offset,
  output logic [10:0]                out_payload_length,
  output logic [10:0]                out_packet_bytes,
  output logic                       out_last
);

  localparam int JOB_WIDTH = $bits(job_ctl_t) + NAL_LENGTH_BITS;

  logic                       q_push;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  job_ctl_t                   push_ctl;
  logic [NAL_LENGTH_BITS-1:0] push_pay;
  job_ctl_t                   head_ctl;
  logic [NAL_LENGTH_BITS-1:0] head_pay;
  logic [JOB_WIDTH-1:0]       head_data;
  logic                       out_valid;
  pkt_t                       out_pkt;

  // The configuration registers accept a write in every cycle.
  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  rfu_front #(
    .NAL_LENGTH_BITS(NAL_LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_nal_header (in_nal_header),
    .in_nal_length (in_nal_length),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ctl         (push_ctl),
    .q_pay         (push_pay)
  );

  rfu_job_queue #(
    .WIDTH(JOB_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_ctl, push_pay}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_data (head_data)
  );

  assign head_ctl = head_data[JOB_WIDTH-1:NAL_LENGTH_BITS];
  assign head_pay = head_data[NAL_LENGTH_BITS-1:0];

  rfu_back #(
    .NAL_LENGTH_BITS(NAL_LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ctl   (head_ctl),
    .job_pay   (head_pay),
    .job_pop   (q_pop),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .out_pkt   (out_pkt)
  );

  assign out_empty          = !out_valid;
  assign out_seq_number     = out_pkt.seq_number;
  assign out_timestamp      = out_pkt.timestamp;
  assign out_marker         = out_pkt.marker;
  assign out_fragmented     = out_pkt.fragmented;
  assign out_lead_byte      = out_pkt.lead_byte;
  assign out_fu_hdr         = out_pkt.fu_hdr;
  assign out_payload_offset = out_pkt.payload_offset;
  assign out_payload_length = out_pkt.payload_length;
  assign out_packet_bytes   = out_pkt.packet_bytes;
  assign out_last           = out_pkt.last;

  // The back stage must never take a job from an empty queue.
  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job queue popped while empty");

  // The marker bit and the last flag agree on every packet.
  a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_marker == out_last))
    else $error("marker and last disagree");

  // A single-NAL packet is always the only packet of its NAL unit.
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_fragmented) |-> (out_last && out_fu_hdr == 8'd0))
    else $error("single packet not closing its NAL unit");

  // A fragment never carries start and end together and keeps R clear.
  a_fu_hdr_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_fragmented) |->
      (!out_fu_hdr[5] && !(out_fu_hdr[7] && out_fu_hdr[6])))
    else $error("malformed FU header");

endmodule

// ----- rtl/rfu_front.sv -----
`timescale 1ns / 1ps
module rfu_front import rfu_pkg::*; #(
  parameter int NAL_LENGTH_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                       in_push,
  input  logic [7:0]                 in_nal_header,
  input  logic [NAL_LENGTH_BITS-1:0] in_nal_length,
  input  logic                       q_full,
  output logic                       q_push,
  output job_ctl_t                   q_ctl,
  output logic [NAL_LENGTH_BITS-1:0] q_pay
);

  logic [16:0] ts_step_r;
  logic [10:0] max_pay_r;
  logic [31:0] ts_r;
  logic [31:0] ts_nxt;
  logic [10:0] max_pay_eff;
  logic [NAL_LENGTH_BITS-1:0] len_eff;

  always_comb begin
    if (max_pay_r < PAYLOAD_MIN) begin
      max_pay_eff = PAYLOAD_MIN;
    end else if (max_pay_r > PAYLOAD_MAX) begin
      max_pay_eff = PAYLOAD_MAX;
    end else begin
      max_pay_eff = max_pay_r;
    end
  end

  // A zero length is taken as a NAL unit of one byte.
  assign len_eff = (in_nal_length == '0) ? NAL_LENGTH_BITS'(1) : in_nal_length;
  assign ts_nxt  = ts_r + 32'(ts_step_r);
  assign q_push  = in_push && !q_full;

  always_comb begin
    q_ctl.hdr     = in_nal_header;
    q_ctl.single  = (len_eff <= NAL_LENGTH_BITS'(max_pay_eff));
    q_ctl.max_pay = max_pay_eff;
    q_ctl.ts      = ts_nxt;
    q_pay         = len_eff - NAL_LENGTH_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_step_r <= TIMESTAMP_STEP_RESET;
      max_pay_r <= MAX_PAYLOAD_RESET;
      ts_r      <= '0;
    end else begin
      if (cfg_valid && cfg_index == CFG_TIMESTAMP_STEP) begin
        ts_step_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == CFG_MAX_PAYLOAD) begin
        max_pay_r <= cfg_data[10:0];
      end
      if (q_push) begin
        ts_r <= ts_nxt;
      end
    end
  end

endmodule

// ----- rtl/rfu_job_queue.sv -----
`timescale 1ns / 1ps
module rfu_job_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;

  assign full      = (count_r == 2'd2);
  assign valid     = (count_r != 2'd0);
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/rfu_back.sv -----
`timescale 1ns / 1ps
module rfu_back import rfu_pkg::*; #(
  parameter int NAL_LENGTH_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  input  job_ctl_t                   job_ctl,
  input  logic [NAL_LENGTH_BITS-1:0] job_pay,
  output logic                       job_pop,
  input  logic                       out_pop,
  output logic                       out_valid,
  output pkt_t                       out_pkt
);

  back_state_t state_r, state_nxt;

  logic [7:0]                 hdr_r;
  logic [10:0]                max_pay_r;
  logic [31:0]                ts_r;
  logic [NAL_LENGTH_BITS-1:0] rem_r;
  logic [15:0]                off_r;
  logic [FRAG_IDX_BITS-1:0]   idx_r;
  logic [15:0]                seq_r;
  logic                       out_valid_r;
  pkt_t                       pkt_r;

  logic       slot_free;
  logic       rem_fits;
  logic       frag_last;
  logic [10:0] frag_len;
  logic       load;
  logic       emit;
  pkt_t       pkt_nxt;

  assign slot_free = !out_valid_r || out_pop;
  assign rem_fits  = (rem_r <= NAL_LENGTH_BITS'(max_pay_r));
  // The first fragment is never the last, so S and E never meet; the
  // 64th fragment closes the NAL unit whatever remains.
  assign frag_last = ((idx_r != '0) && rem_fits) || (idx_r == '1);
  assign frag_len  = (frag_last && rem_fits) ? rem_r[10:0] : max_pay_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid && !job_ctl.single) begin
          state_nxt = BK_FRAG;
        end
      end
      BK_FRAG: begin
        if (slot_free && frag_last) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    load    = 1'b0;
    emit    = 1'b0;
    pkt_nxt = '0;
    pkt_nxt.seq_number = seq_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid && !job_ctl.single) begin
          job_pop = 1'b1;
          load    = 1'b1;
        end else if (job_valid && slot_free) begin
          job_pop                = 1'b1;
          emit                   = 1'b1;
          pkt_nxt.timestamp      = job_ctl.ts;
          pkt_nxt.marker         = 1'b1;
          pkt_nxt.fragmented     = 1'b0;
          pkt_nxt.lead_byte      = job_ctl.hdr;
          pkt_nxt.fu_hdr         = 8'd0;
          pkt_nxt.payload_offset = 16'd1;
          pkt_nxt.payload_length = job_pay[10:0];
          pkt_nxt.packet_bytes   = SINGLE_OVERHEAD + job_pay[10:0];
          pkt_nxt.last           = 1'b1;
        end
      end
      BK_FRAG: begin
        if (slot_free) begin
          emit                   = 1'b1;
          pkt_nxt.timestamp      = ts_r;
          pkt_nxt.marker         = frag_last;
          pkt_nxt.fragmented     = 1'b1;
          pkt_nxt.lead_byte      = {hdr_r[7:5], FU_A_TYPE};
          pkt_nxt.fu_hdr         = {(idx_r == '0), frag_last, 1'b0, hdr_r[4:0]};
          pkt_nxt.payload_offset = off_r;
          pkt_nxt.payload_length = frag_len;
          pkt_nxt.packet_bytes   = FU_OVERHEAD + frag_len;
          pkt_nxt.last           = frag_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hdr_r     <= job_ctl.hdr;
      max_pay_r <= job_ctl.max_pay;
      ts_r      <= job_ctl.ts;
      rem_r     <= job_pay;
      off_r     <= 16'd1;
      idx_r     <= '0;
    end else if (emit && state_r == BK_FRAG) begin
      rem_r <= rem_r - NAL_LENGTH_BITS'(max_pay_r);
      off_r <= off_r + 16'(max_pay_r);
      idx_r <= idx_r + FRAG_IDX_BITS'(1);
    end
    if (emit) begin
      pkt_r <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        seq_r       <= seq_r + 16'd1;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pkt   = pkt_r;

endmodule
